### src/sase_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array stack engine package
// Shared sizes, operation codes, status codes and configuration register indexes.
// ----------------------------------------------------------------------------
package sase_pkg;

    // Storage geometry
    localparam int DEPTH  = 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int VAL_W  = 32;
    localparam int ACT_W  = 4;
    localparam int STAT_W = 3;

    typedef logic [CNT_W-1:0]  t_count;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [VAL_W-1:0]  t_value;

    // Operation codes
    localparam logic [ACT_W-1:0] ACT_PUSH     = 4'd0;
    localparam logic [ACT_W-1:0] ACT_POP      = 4'd1;
    localparam logic [ACT_W-1:0] ACT_TOP      = 4'd2;
    localparam logic [ACT_W-1:0] ACT_GET      = 4'd3;
    localparam logic [ACT_W-1:0] ACT_SET      = 4'd4;
    localparam logic [ACT_W-1:0] ACT_INSERT   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_DELETE   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_ORDERED  = 4'd7;
    localparam logic [ACT_W-1:0] ACT_BSEARCH  = 4'd8;
    localparam logic [ACT_W-1:0] ACT_LSEARCH  = 4'd9;
    localparam logic [ACT_W-1:0] ACT_CLEAR    = 4'd10;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd2;
    localparam logic [STAT_W-1:0] ST_BADIDX = 3'd3;
    localparam logic [STAT_W-1:0] ST_DUP    = 3'd4;

    // Configuration register indexes
    localparam logic REG_DESCENDING = 1'b0;
    localparam logic REG_REJECT_DUP = 1'b1;

endpackage

### src/sorted_array_stack_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array stack engine
// Bounded array of signed values with stack, indexed, ordered and search
// operations, held in one synchronous memory with a sequencer around it.
// ----------------------------------------------------------------------------
// Channel      | Handshake                      | Payload
// -------------+--------------------------------+-----------------------------
// request in   | start, busy (taken: start&!busy) | i_action, i_slot_index,
//              |                                | i_item_value
// result out   | o_done, one cycle, no stall    | o_out_value, o_position,
//              |                                | o_found, o_length, o_status
// config       | APB: psel, penable, pwrite     | paddr, pwdata, prdata
//
// One request at a time. Push, set, clear and most error cases finish in
// the execute state; pop, top and get then wait for the registered memory
// read. Insert moves the entries from the target up and delete the entries
// above the target down (none for the last entry), one entry moved per
// cycle through the single read and write port. Binary search reads, then
// compares, on each probe, at most nine probes; linear search scans in order.
// Reset empties the array at once; memory contents need no clearing.
// ----------------------------------------------------------------------------
module sorted_array_stack_engine_unit
    import sase_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel
    input  logic              start,
    output logic              busy,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [CNT_W-1:0]  i_slot_index,
    input  logic [VAL_W-1:0]  i_item_value,
    // Result channel
    output logic              o_done,
    output logic [VAL_W-1:0]  o_out_value,
    output logic [CNT_W-1:0]  o_position,
    output logic              o_found,
    output logic [CNT_W-1:0]  o_length,
    output logic [STAT_W-1:0] o_status,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EXEC     = 4'd1;
    localparam logic [3:0] S_RDOUT    = 4'd2;
    localparam logic [3:0] S_SHIFT    = 4'd3;
    localparam logic [3:0] S_INS_LAST = 4'd4;
    localparam logic [3:0] S_BS_READ  = 4'd5;
    localparam logic [3:0] S_BS_CMP   = 4'd6;
    localparam logic [3:0] S_BS_DONE  = 4'd7;
    localparam logic [3:0] S_LIN      = 4'd8;

    localparam t_count FULL_COUNT = CNT_W'(DEPTH);

    // Control registers
    logic [3:0] r_state, n_state;
    t_count     r_count, n_count;
    logic       r_desc, r_rejdup;
    logic       r_done, n_done;

    // Request and working registers
    logic [ACT_W-1:0] r_action, n_action;
    t_count           r_idx, n_idx;
    t_value           r_value, n_value;
    t_count           r_ptr, n_ptr;
    t_count           r_src, n_src;
    t_count           r_left, n_left;
    logic             r_pend, n_pend;
    logic             r_up, n_up;
    t_count           r_ins, n_ins;
    t_count           r_lo, n_lo;
    t_count           r_hip1, n_hip1;
    t_count           r_mid, n_mid;
    t_count           r_pos, n_pos;
    logic             r_hit, n_hit;

    // Result registers
    t_value           r_out_value, n_out_value;
    t_count           r_out_pos, n_out_pos;
    logic             r_out_found, n_out_found;
    t_count           r_out_len, n_out_len;
    logic [STAT_W-1:0] r_out_stat, n_out_stat;

    // Memory
    t_value r_mem [DEPTH];
    t_value r_rd_data;
    logic   mem_we;
    t_addr  mem_waddr;
    t_value mem_wdata;
    t_addr  mem_raddr;

    // Sequencer helpers
    logic              fin;
    logic [STAT_W-1:0] fin_status;
    t_value            fin_value;
    logic              ins_go;
    t_count            ins_tgt;
    logic [CNT_W:0]    bs_sum;
    t_count            bs_mid;
    logic              go_low;
    logic              cfg_wr;
    t_count            top_idx;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            REG_DESCENDING: prdata[0] = r_desc;
            REG_REJECT_DUP: prdata[0] = r_rejdup;
            default:        prdata    = '0;
        endcase
    end

    // Position of the top entry when the array is not empty.
    assign top_idx = r_count - CNT_W'(1);

    // Binary search midpoint and direction
    assign bs_sum = {1'b0, r_lo} + {1'b0, r_hip1} - (CNT_W+1)'(1);
    assign bs_mid = bs_sum[CNT_W:1];
    assign go_low = r_desc ? ($signed(r_rd_data) < $signed(r_value))
                           : ($signed(r_rd_data) > $signed(r_value));

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_done      = 1'b0;
        n_action    = r_action;
        n_idx       = r_idx;
        n_value     = r_value;
        n_ptr       = r_ptr;
        n_src       = r_src;
        n_left      = r_left;
        n_pend      = r_pend;
        n_up        = r_up;
        n_ins       = r_ins;
        n_lo        = r_lo;
        n_hip1      = r_hip1;
        n_mid       = r_mid;
        n_pos       = r_pos;
        n_hit       = r_hit;
        n_out_value = r_out_value;
        n_out_pos   = r_out_pos;
        n_out_found = r_out_found;
        n_out_len   = r_out_len;
        n_out_stat  = r_out_stat;
        mem_we      = 1'b0;
        mem_waddr   = r_src[ADDR_W-1:0];
        mem_wdata   = r_rd_data;
        mem_raddr   = r_ptr[ADDR_W-1:0];
        fin         = 1'b0;
        fin_status  = ST_OK;
        fin_value   = '0;
        ins_go      = 1'b0;
        ins_tgt     = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_action = i_action;
                    n_idx    = i_slot_index;
                    n_value  = i_item_value;
                    n_pos    = '0;
                    n_hit    = 1'b0;
                    n_state  = S_EXEC;
                end
            end

            S_EXEC: begin
                unique case (r_action) inside
                    ACT_PUSH: begin
                        fin = 1'b1;
                        if (r_count == FULL_COUNT) begin
                            fin_status = ST_FULL;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_count[ADDR_W-1:0];
                            mem_wdata = r_value;
                            n_count   = r_count + CNT_W'(1);
                        end
                    end
                    ACT_POP, ACT_TOP: begin
                        if (r_count == '0) begin
                            fin        = 1'b1;
                            fin_status = ST_EMPTY;
                        end else begin
                            mem_raddr = top_idx[ADDR_W-1:0];
                            if (r_action == ACT_POP) begin
                                n_count = r_count - CNT_W'(1);
                            end
                            n_state = S_RDOUT;
                        end
                    end
                    ACT_GET: begin
                        if (r_idx >= r_count) begin
                            fin        = 1'b1;
                            fin_status = ST_BADIDX;
                        end else begin
                            mem_raddr = r_idx[ADDR_W-1:0];
                            n_state   = S_RDOUT;
                        end
                    end
                    ACT_SET: begin
                        fin = 1'b1;
                        if (r_idx >= r_count) begin
                            fin_status = ST_BADIDX;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_idx[ADDR_W-1:0];
                            mem_wdata = r_value;
                        end
                    end
                    ACT_INSERT: begin
                        if (r_idx > r_count) begin
                            fin        = 1'b1;
                            fin_status = ST_BADIDX;
                        end else if (r_count == FULL_COUNT) begin
                            fin        = 1'b1;
                            fin_status = ST_FULL;
                        end else begin
                            ins_go  = 1'b1;
                            ins_tgt = r_idx;
                        end
                    end
                    ACT_DELETE: begin
                        if (r_idx >= r_count) begin
                            fin        = 1'b1;
                            fin_status = ST_BADIDX;
                        end else if (r_count - CNT_W'(1) == r_idx) begin
                            // Last entry: nothing to move down.
                            fin     = 1'b1;
                            n_count = r_count - CNT_W'(1);
                        end else begin
                            n_up    = 1'b0;
                            n_ptr   = r_idx + CNT_W'(1);
                            n_left  = r_count - CNT_W'(1) - r_idx;
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                    ACT_ORDERED, ACT_BSEARCH: begin
                        n_lo    = '0;
                        n_hip1  = r_count;
                        n_state = S_BS_READ;
                    end
                    ACT_LSEARCH: begin
                        n_ptr   = '0;
                        n_pend  = 1'b0;
                        n_state = S_LIN;
                    end
                    ACT_CLEAR: begin
                        fin     = 1'b1;
                        n_count = '0;
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end

            // Read data from the cycle before is now registered.
            S_RDOUT: begin
                fin       = 1'b1;
                fin_value = r_rd_data;
            end

            // Move one entry per cycle: read the source, write it one slot
            // up or down in the following cycle.
            S_SHIFT: begin
                if (r_pend) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_up ? r_src[ADDR_W-1:0] + ADDR_W'(1)
                                     : r_src[ADDR_W-1:0] - ADDR_W'(1);
                    mem_wdata = r_rd_data;
                end
                if (r_left != '0) begin
                    mem_raddr = r_ptr[ADDR_W-1:0];
                    n_src     = r_ptr;
                    n_pend    = 1'b1;
                    n_left    = r_left - CNT_W'(1);
                    n_ptr     = r_up ? r_ptr - CNT_W'(1) : r_ptr + CNT_W'(1);
                end else begin
                    n_pend = 1'b0;
                    if (r_up) begin
                        n_state = S_INS_LAST;
                    end else begin
                        fin     = 1'b1;
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end

            S_INS_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = r_ins[ADDR_W-1:0];
                mem_wdata = r_value;
                n_count   = r_count + CNT_W'(1);
                fin       = 1'b1;
            end

            S_BS_READ: begin
                if (r_lo < r_hip1) begin
                    mem_raddr = bs_mid[ADDR_W-1:0];
                    n_mid     = bs_mid;
                    n_state   = S_BS_CMP;
                end else begin
                    n_pos   = r_lo;
                    n_hit   = 1'b0;
                    n_state = S_BS_DONE;
                end
            end

            S_BS_CMP: begin
                if (r_rd_data == r_value) begin
                    n_pos   = r_mid;
                    n_hit   = 1'b1;
                    n_state = S_BS_DONE;
                end else begin
                    if (go_low) begin
                        n_hip1 = r_mid;
                    end else begin
                        n_lo = r_mid + CNT_W'(1);
                    end
                    n_state = S_BS_READ;
                end
            end

            // Search finished: report, or go on to the ordered insert.
            S_BS_DONE: begin
                if (r_action == ACT_BSEARCH) begin
                    fin = 1'b1;
                end else if (r_hit && r_rejdup) begin
                    fin        = 1'b1;
                    fin_status = ST_DUP;
                end else if (r_count == FULL_COUNT) begin
                    fin        = 1'b1;
                    fin_status = ST_FULL;
                end else begin
                    ins_go  = 1'b1;
                    ins_tgt = r_pos;
                end
            end

            // Linear scan: one read per cycle, each compared in the cycle after its read.
            S_LIN: begin
                if (r_pend && (r_rd_data == r_value)) begin
                    n_pos = r_src;
                    n_hit = 1'b1;
                    fin   = 1'b1;
                end else if (r_ptr < r_count) begin
                    mem_raddr = r_ptr[ADDR_W-1:0];
                    n_src     = r_ptr;
                    n_pend    = 1'b1;
                    n_ptr     = r_ptr + CNT_W'(1);
                end else begin
                    fin = 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Start of an insert: shift the upper part first if there is one.
        if (ins_go) begin
            n_ins  = ins_tgt;
            n_up   = 1'b1;
            n_pend = 1'b0;
            n_ptr  = r_count - CNT_W'(1);
            n_left = r_count - ins_tgt;
            if (r_count == ins_tgt) begin
                n_state = S_INS_LAST;
            end else begin
                n_state = S_SHIFT;
            end
        end

        // Result capture
        if (fin) begin
            n_state     = S_IDLE;
            n_done      = 1'b1;
            n_out_value = fin_value;
            n_out_pos   = n_pos;
            n_out_found = n_hit;
            n_out_len   = n_count;
            n_out_stat  = fin_status;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_desc   <= 1'b0;
            r_rejdup <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            if (cfg_wr) begin
                if (paddr[2] == REG_DESCENDING) begin
                    r_desc <= pwdata[0];
                end else begin
                    r_rejdup <= pwdata[0];
                end
            end
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_idx       <= n_idx;
        r_value     <= n_value;
        r_ptr       <= n_ptr;
        r_src       <= n_src;
        r_left      <= n_left;
        r_pend      <= n_pend;
        r_up        <= n_up;
        r_ins       <= n_ins;
        r_lo        <= n_lo;
        r_hip1      <= n_hip1;
        r_mid       <= n_mid;
        r_pos       <= n_pos;
        r_hit       <= n_hit;
        r_out_value <= n_out_value;
        r_out_pos   <= n_out_pos;
        r_out_found <= n_out_found;
        r_out_len   <= n_out_len;
        r_out_stat  <= n_out_stat;
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[mem_raddr];
    end

    // Outputs
    assign busy        = (r_state != S_IDLE);
    assign o_done      = r_done;
    assign o_out_value = r_out_value;
    assign o_position  = r_out_pos;
    assign o_found     = r_out_found;
    assign o_length    = r_out_len;
    assign o_status    = r_out_stat;

endmodule

### src/sase_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted array stack engine checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module sase_props
    import sase_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input logic [VAL_W-1:0]  o_out_value,
    input logic              o_found,
    input logic [CNT_W-1:0]  o_length,
    input logic [STAT_W-1:0] o_status
);

    // A taken request keeps the engine busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("engine not busy after a request was taken");

    // The engine only goes idle by delivering a result.
    a_fell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("busy dropped without a result");

    // A result always closes a request that was in progress.
    a_done_past: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (!busy && $past(busy)))
        else $error("result without a request in progress");

    // A full status only with a full array.
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_FULL)) |-> (o_length == CNT_W'(DEPTH)))
        else $error("full status with room left");

    // An empty status reports nothing stored and no value.
    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_EMPTY)) |-> ((o_length == '0) && (o_out_value == '0)
            && !o_found))
        else $error("empty status with entries or data");

endmodule

bind sorted_array_stack_engine_unit sase_props u_sase_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_done      (o_done),
    .o_out_value (o_out_value),
    .o_found     (o_found),
    .o_length    (o_length),
    .o_status    (o_status)
);
